/* hdl/alg_pkg.sv */
package alg_pkg;

  // Field widths of the gate.
  localparam int LevelW   = 16;  // Q8.8 dB levels and thresholds
  localparam int HystW    = 15;  // unsigned Q7.8 dB hysteresis margin
  localparam int IntW     = 9;   // intensity, 256 means 1.0
  localparam int TickW    = 16;  // hold and release counters
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // Working widths. A signed difference of two levels fits in two extra bits.
  localparam int DiffW = LevelW + 2;
  // Products are a 9 bit intensity times a 16 bit count or span.
  localparam int ProdW = IntW + TickW;
  // Every quotient of this block is below 512, so the divider only
  // produces an intensity wide result.
  localparam int QuotW = IntW;
  localparam int CntW  = $clog2(QuotW + 1);

  // Reset values of the configuration registers.
  localparam logic                     RstEnable  = 1'b0;
  localparam logic signed [LevelW-1:0] RstLowThr  = -16'sd10240;
  localparam logic signed [LevelW-1:0] RstHighThr = 16'sd0;
  localparam logic        [HystW-1:0]  RstHyst    = 15'd768;
  localparam logic        [IntW-1:0]   RstFloor   = 9'd0;
  localparam logic        [IntW-1:0]   RstCeil    = 9'd256;
  localparam logic        [TickW-1:0]  RstHold    = 16'd0;
  localparam logic        [TickW-1:0]  RstRelease = 16'd100;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ENABLE   = 3'd0,
    CFG_LOW_THR  = 3'd1,
    CFG_HIGH_THR = 3'd2,
    CFG_HYST     = 3'd3,
    CFG_FLOOR    = 3'd4,
    CFG_CEIL     = 3'd5,
    CFG_HOLD     = 3'd6,
    CFG_RELEASE  = 3'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECIDE,
    S_CLAMP,
    S_MUL0,
    S_MUL1,
    S_MAP_DIV,
    S_MAP_WAIT,
    S_TICK,
    S_REL_MUL,
    S_REL_DIV,
    S_REL_WAIT,
    S_DONE
  } state_e;

  typedef struct packed {
    logic             start;
    logic [ProdW-1:0] dividend;
    logic [TickW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QuotW-1:0] quotient;
  } div_rsp_t;

endpackage

/* hdl/alg_div.sv */
// Restoring divider, one quotient bit per cycle. The caller guarantees that
// the dividend is below the divisor times 2**QuotW, so the top bits of the
// dividend already form a partial remainder smaller than the divisor.
module alg_div (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  alg_pkg::div_req_t req_i,
  output alg_pkg::div_rsp_t rsp_o
);
  import alg_pkg::*;

  logic [TickW-1:0] rem_q, rem_d;
  logic [QuotW-1:0] quo_q, quo_d;
  logic [TickW-1:0] dvs_q, dvs_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             done_q, done_d;
  logic [TickW:0]   trial;
  logic [TickW:0]   diff;
  logic             fits;

  assign trial = {rem_q, quo_q[QuotW-1]};
  assign diff  = trial - {1'b0, dvs_q};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (req_i.start) begin
      rem_d = req_i.dividend[ProdW-1:QuotW];
      quo_d = req_i.dividend[QuotW-1:0];
      dvs_d = req_i.divisor;
      cnt_d = CntW'(QuotW);
    end else if (cnt_q != '0) begin
      rem_d  = fits ? diff[TickW-1:0] : trial[TickW-1:0];
      quo_d  = {quo_q[QuotW-2:0], fits};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

/* hdl/audio_level_gate_hold_release.sv */
// Noise gate with hysteresis, hold and release, stepped once per millisecond
// tick. Each input transfer is one tick; a tick with window_done_i set also
// carries a fresh window level in Q8.8 dB. Every tick produces exactly one
// output transfer with the gate intensity (256 means 1.0) and the open flag.
// A closed gate opens when the level exceeds the low threshold and stays open
// while the level exceeds the low threshold minus the hysteresis. While open,
// the level is mapped linearly between the low and high thresholds onto the
// floor and ceiling intensities. After closing, the last intensity is held
// for hold_ticks ticks and then ramped down linearly over release_ticks ticks.
// With the gate disabled every tick returns zero and the state is kept.
// The block works on one tick at a time: its input is not ready again until
// the current tick has been handed to the output register. A zero span maps
// straight to the ceiling. A tick may remap the level or scale a release
// ramp step, but never both. Both use one 9x16 multiplier and one nine step
// serial divider, which the sequencer shares between the level mapping and
// the release ramp. A finished result sits in an output register, so the
// next tick may be taken while the previous result still waits; a tick that
// finishes while that register is still full waits until it is emptied.
// Configuration writes are taken at any time but must only be issued while
// no tick is in flight.
module audio_level_gate_hold_release (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [alg_pkg::CfgIdxW-1:0]          cfg_idx_i,
  input  logic [alg_pkg::CfgDataW-1:0]         cfg_data_i,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 window_done_i,
  input  logic signed [alg_pkg::LevelW-1:0]    level_db_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic [alg_pkg::IntW-1:0]             intensity_o,
  output logic                                 gate_open_o
);
  import alg_pkg::*;

  // Configuration registers.
  logic                     en_q;
  logic signed [LevelW-1:0] low_q;
  logic signed [LevelW-1:0] high_q;
  logic [HystW-1:0]         hyst_q;
  logic [IntW-1:0]          floor_q;
  logic [IntW-1:0]          ceil_q;
  logic [TickW-1:0]         hold_ticks_q;
  logic [TickW-1:0]         rel_ticks_q;

  // Gate state that survives from tick to tick.
  logic             open_q, open_d;
  logic [TickW-1:0] hold_q, hold_d;
  logic [TickW-1:0] rel_q, rel_d;
  logic [IntW-1:0]  held_q, held_d;

  // Sequencer and working registers of the current tick.
  state_e                  state_q, state_d;
  logic                    wd_q, wd_d;
  logic signed [DiffW-1:0] lvl_q, lvl_d;
  logic signed [DiffW-1:0] den_q, den_d;
  logic signed [DiffW-1:0] num_q, num_d;
  logic [TickW-1:0]        d_q, d_d;
  logic [TickW-1:0]        n_q, n_d;
  logic [ProdW-1:0]        prod_q, prod_d;
  logic [IntW-1:0]         res_q, res_d;

  // Output register.
  logic            out_valid_q, out_valid_d;
  logic [IntW-1:0] out_int_q, out_int_d;
  logic            out_open_q, out_open_d;

  // Shared multiplier and divider.
  logic [IntW-1:0]  mul_a;
  logic [TickW-1:0] mul_b;
  logic [ProdW-1:0] mul_p;
  div_req_t         div_req;
  div_rsp_t         div_rsp;

  logic signed [DiffW-1:0] low_ext;
  logic signed [DiffW-1:0] high_ext;
  logic signed [DiffW-1:0] keep_thr;
  logic signed [DiffW-1:0] den_abs;
  logic signed [DiffW-1:0] num_adj;

  assign low_ext  = DiffW'(low_q);
  assign high_ext = DiffW'(high_q);
  // Level an open gate must stay above to remain open.
  assign keep_thr = low_ext - $signed({{(DiffW - HystW){1'b0}}, hyst_q});

  // A negative span maps the other way round; flip both terms so that the
  // fraction excess / span keeps its sign.
  assign den_abs = den_q[DiffW-1] ? -den_q : den_q;
  assign num_adj = den_q[DiffW-1] ? -num_q : num_q;

  assign mul_p = ProdW'(mul_a) * ProdW'(mul_b);

  alg_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q         <= RstEnable;
      low_q        <= RstLowThr;
      high_q       <= RstHighThr;
      hyst_q       <= RstHyst;
      floor_q      <= RstFloor;
      ceil_q       <= RstCeil;
      hold_ticks_q <= RstHold;
      rel_ticks_q  <= RstRelease;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_ENABLE:   en_q         <= cfg_data_i[0];
        CFG_LOW_THR:  low_q        <= $signed(cfg_data_i[LevelW-1:0]);
        CFG_HIGH_THR: high_q       <= $signed(cfg_data_i[LevelW-1:0]);
        CFG_HYST:     hyst_q       <= cfg_data_i[HystW-1:0];
        CFG_FLOOR:    floor_q      <= cfg_data_i[IntW-1:0];
        CFG_CEIL:     ceil_q       <= cfg_data_i[IntW-1:0];
        CFG_HOLD:     hold_ticks_q <= cfg_data_i[TickW-1:0];
        CFG_RELEASE:  rel_ticks_q  <= cfg_data_i[TickW-1:0];
      endcase
    end
  end

  // Next state and datapath control of the tick sequencer.
  always_comb begin
    state_d     = state_q;
    open_d      = open_q;
    hold_d      = hold_q;
    rel_d       = rel_q;
    held_d      = held_q;
    wd_d        = wd_q;
    lvl_d       = lvl_q;
    den_d       = den_q;
    num_d       = num_q;
    d_d         = d_q;
    n_d         = n_q;
    prod_d      = prod_q;
    res_d       = res_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    out_int_d   = out_int_q;
    out_open_d  = out_open_q;
    mul_a       = floor_q;
    mul_b       = d_q - n_q;
    div_req.start    = 1'b0;
    div_req.dividend = prod_q;
    div_req.divisor  = d_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          wd_d  = window_done_i;
          lvl_d = DiffW'(level_db_i);
          if (en_q) begin
            state_d = S_DECIDE;
          end else begin
            // Disabled: zero result and no state update.
            res_d   = '0;
            state_d = S_DONE;
          end
        end
      end

      S_DECIDE: begin
        den_d   = high_ext - low_ext;
        num_d   = lvl_q - low_ext;
        state_d = S_TICK;
        if (wd_q) begin
          if (open_q) begin
            if (lvl_q > keep_thr) begin
              state_d = S_CLAMP;
            end else begin
              open_d = 1'b0;
              hold_d = hold_ticks_q;
              if (hold_ticks_q == '0) begin
                rel_d = rel_ticks_q;
              end
            end
          end else if (lvl_q > low_ext) begin
            open_d  = 1'b1;
            hold_d  = '0;
            rel_d   = '0;
            state_d = S_CLAMP;
          end
        end
      end

      S_CLAMP: begin
        if (den_q == '0) begin
          // Zero span gives full ceiling.
          held_d  = ceil_q;
          state_d = S_TICK;
        end else begin
          d_d = den_abs[TickW-1:0];
          if (num_adj[DiffW-1]) begin
            n_d = '0;
          end else if (num_adj > den_abs) begin
            n_d = den_abs[TickW-1:0];
          end else begin
            n_d = num_adj[TickW-1:0];
          end
          state_d = S_MUL0;
        end
      end

      S_MUL0: begin
        mul_a   = floor_q;
        mul_b   = d_q - n_q;
        prod_d  = mul_p;
        state_d = S_MUL1;
      end

      S_MUL1: begin
        mul_a   = ceil_q;
        mul_b   = n_q;
        prod_d  = prod_q + mul_p;
        state_d = S_MAP_DIV;
      end

      S_MAP_DIV: begin
        div_req.start = 1'b1;
        state_d       = S_MAP_WAIT;
      end

      S_MAP_WAIT: begin
        if (div_rsp.done) begin
          held_d  = div_rsp.quotient;
          state_d = S_TICK;
        end
      end

      S_TICK: begin
        state_d = S_DONE;
        if (open_q) begin
          res_d = held_q;
        end else if (hold_q != '0) begin
          res_d  = held_q;
          hold_d = hold_q - 1'b1;
          if (hold_q == TickW'(1)) begin
            rel_d = rel_ticks_q;
          end
        end else if (rel_q != '0) begin
          if (rel_q >= rel_ticks_q) begin
            // Ramp longer than its register: ratio saturates at one.
            res_d = held_q;
            rel_d = rel_q - 1'b1;
          end else begin
            state_d = S_REL_MUL;
          end
        end else begin
          held_d = '0;
          res_d  = '0;
        end
      end

      S_REL_MUL: begin
        mul_a   = held_q;
        mul_b   = rel_q;
        prod_d  = mul_p;
        rel_d   = rel_q - 1'b1;
        state_d = S_REL_DIV;
      end

      S_REL_DIV: begin
        div_req.start   = 1'b1;
        div_req.divisor = rel_ticks_q;
        state_d         = S_REL_WAIT;
      end

      S_REL_WAIT: begin
        if (div_rsp.done) begin
          res_d   = div_rsp.quotient;
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        // Wait until the output register is free or being emptied.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_int_d   = res_q;
          out_open_d  = en_q & open_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      open_q      <= 1'b0;
      hold_q      <= '0;
      rel_q       <= '0;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      open_q      <= open_d;
      hold_q      <= hold_d;
      rel_q       <= rel_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    wd_q      <= wd_d;
    lvl_q     <= lvl_d;
    den_q     <= den_d;
    num_q     <= num_d;
    d_q       <= d_d;
    n_q       <= n_d;
    prod_q    <= prod_d;
    res_q     <= res_d;
    out_int_q <= out_int_d;
    out_open_q <= out_open_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign intensity_o = out_int_q;
  assign gate_open_o = out_open_q;

  // The hold counter only runs on a closed gate.
  a_hold_closed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (hold_q != '0) |-> !open_q)
    else $error("hold counter running while gate is open");

  // Opening clears the release ramp and nothing reloads it while open.
  a_release_closed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    open_q |-> (rel_q == '0))
    else $error("release ramp active while gate is open");

  // A divider result only arrives while the sequencer waits for it.
  a_div_done_wait : assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_rsp.done |-> (state_q == S_MAP_WAIT || state_q == S_REL_WAIT))
    else $error("divider finished outside a wait state");

  // One tick at a time: a transfer in closes the input until it is done.
  a_one_tick : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("input taken again before the tick was finished");

endmodule
